// File: rtl/br1_pkg.sv
// Shared types and constants of the ByteRun1 row decoder.
`timescale 1ns / 1ps
`default_nettype none

package br1_pkg;

  typedef enum logic [7:0] {
    PH_HDR    = 8'b0000_0001,
    PH_LIT    = 8'b0000_0010,
    PH_DROP   = 8'b0000_0100,
    PH_RUN    = 8'b0000_1000,
    PH_ROW    = 8'b0001_0000,
    PH_ROWPAD = 8'b0010_0000,
    PH_PAD    = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_LENGTH = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgDataW = 32;

  localparam logic        ModeReset   = 1'b1;
  localparam logic [15:0] WidthReset  = 16'd320;
  localparam logic [15:0] HeightReset = 16'd200;
  localparam logic [31:0] LengthReset = 32'd0;

  localparam logic [7:0]  HdrNoop     = 8'h80;

  typedef struct packed {
    logic        mode;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] length;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [7:0]         literal_left;
    logic               drop_final;
    logic signed [17:0] row_budget;
    logic signed [33:0] bytes_left;
    logic [15:0]        rows_left;
    logic [16:0]        column_left;
  } state_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [7:0] pixel_count;
    logic       body_done;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/br1_if.sv
// Valid/ready stream interfaces for body bytes and pixel runs.
`timescale 1ns / 1ps
`default_nettype none

interface br1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;

  modport source (output valid, output body_byte, input ready);
  modport sink (input valid, input body_byte, output ready);
endinterface

interface br1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic [7:0] pixel_count;
  logic       body_done;

  modport source (output valid, output pixel_value, output pixel_count, output body_done,
                  input ready);
  modport sink (input valid, input pixel_value, input pixel_count, input body_done,
                output ready);
endinterface

`default_nettype wire

// File: rtl/br1_engine.sv
// Decode state, configuration registers and per-byte next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module br1_engine import br1_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output      result_t             res_o
);

  cfg_t   cfg_q, cfg_d;
  state_t st_q, st_d, st_step, st_init, st_next;
  logic [7:0] value;
  logic [7:0] count;
  logic [7:0] nn;
  logic [8:0] nn_ext;
  logic signed [17:0] budget_ld;
  logic signed [17:0] budget_n;

  function automatic state_t settle(state_t s, logic [15:0] w, logic odd_len);
    state_t r;
    phase_e fin;
    r = s;
    fin = odd_len ? PH_PAD : PH_DONE;
    unique case (s.phase)
      PH_HDR: begin
        if (s.bytes_left[33] || s.bytes_left == '0) r.phase = fin;
      end
      PH_LIT: begin
        if (s.literal_left == '0) begin
          if (s.drop_final) begin
            r.phase = PH_DROP;
          end else if (s.bytes_left[33] || s.bytes_left == '0) begin
            r.phase = fin;
          end else begin
            r.phase = PH_HDR;
          end
        end
      end
      PH_ROW: begin
        if (s.rows_left == '0) begin
          r.phase = fin;
        end else if (s.column_left == '0) begin
          if (w[0]) begin
            r.phase = PH_ROWPAD;
          end else if (w == '0) begin
            r.rows_left = '0;
            r.phase = fin;
          end else begin
            r.rows_left = s.rows_left - 16'd1;
            r.column_left = {1'b0, w};
            if (r.rows_left == '0) r.phase = fin;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:   cfg_d.mode   = cfg_wdata_i[0];
        REG_WIDTH:  cfg_d.width  = cfg_wdata_i[15:0];
        REG_HEIGHT: cfg_d.height = cfg_wdata_i[15:0];
        REG_LENGTH: cfg_d.length = cfg_wdata_i[31:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    st_init.phase        = cfg_d.mode ? PH_HDR : PH_ROW;
    st_init.literal_left = '0;
    st_init.drop_final   = 1'b0;
    st_init.row_budget   = '0;
    st_init.bytes_left   = {2'b00, cfg_d.length};
    st_init.rows_left    = cfg_d.height;
    st_init.column_left  = {1'b0, cfg_d.width};
  end

  always_comb begin
    st_step   = st_q;
    value     = '0;
    count     = '0;
    nn        = '0;
    nn_ext    = '0;
    budget_ld = (st_q.row_budget[17] || st_q.row_budget == '0) ?
                {2'b00, cfg_q.width} : st_q.row_budget;
    budget_n  = budget_ld;
    unique case (st_q.phase)
      PH_HDR: begin
        if (!byte_i[7]) begin
          nn       = byte_i + 8'd1;
          nn_ext   = {1'b0, nn} + 9'd1;
          budget_n = budget_ld - 18'(nn);
          st_step.bytes_left = st_q.bytes_left - 34'(nn_ext);
          st_step.row_budget = budget_n;
          if (budget_n == '1) begin
            st_step.literal_left = nn - 8'd1;
            st_step.drop_final   = 1'b1;
          end else begin
            st_step.literal_left = nn;
            st_step.drop_final   = 1'b0;
          end
          st_step.phase = PH_LIT;
        end else if (byte_i != HdrNoop) begin
          nn_ext   = 9'd257 - {1'b0, byte_i};
          nn       = nn_ext[7:0];
          budget_n = budget_ld - 18'(nn);
          st_step.bytes_left = st_q.bytes_left - 34'sd2;
          st_step.row_budget = budget_n;
          st_step.literal_left = (budget_n == '1) ? nn - 8'd1 : nn;
          st_step.phase = PH_RUN;
        end else begin
          st_step.row_budget = budget_ld;
          st_step.bytes_left = st_q.bytes_left - 34'sd1;
        end
      end
      PH_LIT: begin
        value = byte_i;
        count = 8'd1;
        st_step.literal_left = st_q.literal_left - 8'd1;
      end
      PH_DROP: begin
        st_step.drop_final = 1'b0;
        st_step.phase = PH_HDR;
      end
      PH_RUN: begin
        value = byte_i;
        count = st_q.literal_left;
        st_step.literal_left = '0;
        st_step.phase = PH_HDR;
      end
      PH_ROW: begin
        value = byte_i;
        count = 8'd1;
        st_step.column_left = st_q.column_left - 17'd1;
      end
      PH_ROWPAD: begin
        st_step.rows_left = st_q.rows_left - 16'd1;
        st_step.column_left = {1'b0, cfg_q.width};
        st_step.phase = PH_ROW;
      end
      PH_PAD: begin
        st_step.phase = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  assign st_next = settle(st_step, cfg_q.width, cfg_q.length[0]);

  always_comb begin
    st_d = st_q;
    if (cfg_we_i) begin
      st_d = settle(st_init, cfg_d.width, cfg_d.length[0]);
    end else if (step_i) begin
      st_d = st_next;
    end
  end

  assign res_o.pixel_value = (count == '0) ? 8'd0 : value;
  assign res_o.pixel_count = count;
  assign res_o.body_done   = (st_next.phase == PH_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= ModeReset;
      cfg_q.width        <= WidthReset;
      cfg_q.height       <= HeightReset;
      cfg_q.length       <= LengthReset;
      st_q.phase         <= PH_DONE;
      st_q.literal_left  <= '0;
      st_q.drop_final    <= 1'b0;
      st_q.row_budget    <= '0;
      st_q.bytes_left    <= {2'b00, LengthReset};
      st_q.rows_left     <= HeightReset;
      st_q.column_left   <= {1'b0, WidthReset};
    end else begin
      cfg_q <= cfg_d;
      st_q  <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/byterun1_row_decoder.sv
// Top level of the ByteRun1 / uncompressed body row decoder.
// Takes one body byte per transfer and returns one pixel run (value, count 0..128,
// body_done) per byte, in order. The path is an input register, decode logic
// against the decode state, and a result register; a byte can be accepted every
// cycle while the output is not stalled, and its result is registered from the
// decode logic. Backpressure on the output holds the result register,
// then the input register. Write the configuration registers only while no
// transfer is pending; every write restarts the body from the new values.
`timescale 1ns / 1ps
`default_nettype none

module byterun1_row_decoder import br1_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  br1_in_if.sink                   in_i,
  br1_out_if.source                out_o
);

  logic       in_v_q;
  logic [7:0] byte_q;
  logic       out_v_q;
  result_t    res_q;
  result_t    res;
  logic       out_free;
  logic       step;

  assign out_free = !out_v_q || out_o.ready;
  assign step     = in_v_q && out_free;
  assign in_i.ready = !in_v_q || out_free;

  br1_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (byte_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_v_q <= 1'b1;
      end else if (step) begin
        in_v_q <= 1'b0;
      end
      if (step) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.body_byte;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.pixel_value = res_q.pixel_value;
  assign out_o.pixel_count = res_q.pixel_count;
  assign out_o.body_done   = res_q.body_done;

endmodule

`default_nettype wire
